>>> rtl/frt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frt_pkg: shared types and codes for the first-match route table
// Mode and status codes, the route entry record and the lookup beat that
// walks the cell chain.
// ----------------------------------------------------------------------------
package frt_pkg;

	localparam int DEFAULT_DEPTH       = 16;
	localparam int DEFAULT_DEVICE_BITS = 4;
	localparam int DEV_W_MAX           = 8;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NO_ROUTE = 2'd2;

	typedef struct packed {
		logic [31:0]          dst;
		logic [31:0]          gateway;
		logic [31:0]          mask;
		logic [7:0]           flags;
		logic [31:0]          metric;
		logic [DEV_W_MAX-1:0] device;
	} entry_t;

	// lookup beat handed from cell to cell
	typedef struct packed {
		logic        valid;
		logic        found;
		logic [31:0] addr;
		entry_t      entry;
	} tok_t;

endpackage
`default_nettype wire

>>> rtl/frt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frt_cell: one route table entry
// Holds a single route and checks the passing lookup beat against it. A
// live cell that has not been beaten by an earlier match makes its own entry
// the beat's candidate, so a missed walk ends holding the last live entry.
// ----------------------------------------------------------------------------
module frt_cell #(
	parameter int          IDX_W       = 4,
	parameter int          DEVICE_BITS = frt_pkg::DEFAULT_DEVICE_BITS,
	parameter logic [IDX_W-1:0] CELL_IDX = '0
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               wr_en,
	input  frt_pkg::entry_t   wr_entry,
	input  wire               live,
	input  frt_pkg::tok_t     tok_in,
	input  wire [IDX_W-1:0]   idx_in,
	output frt_pkg::tok_t     tok_out,
	output logic [IDX_W-1:0]  idx_out
);

	logic [31:0]            dst_q;
	logic [31:0]            gateway_q;
	logic [31:0]            mask_q;
	logic [7:0]             flags_q;
	logic [31:0]            metric_q;
	logic [DEVICE_BITS-1:0] device_q;

	logic            tok_valid_q;
	logic            tok_found_q;
	logic [31:0]     tok_addr_q;
	frt_pkg::entry_t tok_entry_q;
	logic [IDX_W-1:0] idx_q;

	frt_pkg::entry_t own;
	logic            hit;
	logic            take;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			dst_q     <= wr_entry.dst;
			gateway_q <= wr_entry.gateway;
			mask_q    <= wr_entry.mask;
			flags_q   <= wr_entry.flags;
			metric_q  <= wr_entry.metric;
			device_q  <= DEVICE_BITS'(wr_entry.device);
		end
	end

	always_comb begin
		own.dst     = dst_q;
		own.gateway = gateway_q;
		own.mask    = mask_q;
		own.flags   = flags_q;
		own.metric  = metric_q;
		own.device  = frt_pkg::DEV_W_MAX'(device_q);
		hit  = ((tok_in.addr & mask_q) == (dst_q & mask_q));
		take = tok_in.valid && live && !tok_in.found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_addr_q  <= tok_in.addr;
		tok_found_q <= tok_in.found | (take & hit);
		tok_entry_q <= take ? own : tok_in.entry;
		idx_q       <= take ? CELL_IDX : idx_in;
	end

	always_comb begin
		tok_out.valid = tok_valid_q;
		tok_out.found = tok_found_q;
		tok_out.addr  = tok_addr_q;
		tok_out.entry = tok_entry_q;
		idx_out       = idx_q;
	end

endmodule
`default_nettype wire

>>> rtl/first_match_route_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_match_route_table: IPv4 route table, first match in insertion order
// Command port with a one-cycle result strobe; the table is a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//  A command is taken on a clock edge with start high and busy low. mode
//  selects add, lookup or clear; route_* carry the entry for add and
//  lookup_addr the address for lookup.
//  Each command gives one result, shown on the result ports for one cycle
//  with done high. The receiver cannot stall; a result not sampled is lost.
//  Add, clear, full-table add and lookup on an empty table: result in the
//  cycle after the command, and a new command may follow every cycle.
//  Lookup: the address beat walks the TABLE_DEPTH cells one cell per cycle,
//  each cell registering it, and done is registered from the last cell's
//  output. busy is high while the beat walks the chain and the next command
//  is taken at the edge that ends the done cycle. A miss returns the last
//  entry with matched low.
//  Reset empties the table; entry contents are not cleared and are never
//  read before being written.
// ----------------------------------------------------------------------------
module first_match_route_table #(
	parameter int TABLE_DEPTH = frt_pkg::DEFAULT_DEPTH,
	parameter int DEVICE_BITS = frt_pkg::DEFAULT_DEVICE_BITS
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  mode,
	input  wire  [31:0] route_dst,
	input  wire  [31:0] route_gateway,
	input  wire  [31:0] route_mask,
	input  wire  [7:0]  route_flags,
	input  wire  [31:0] route_metric,
	input  wire  [3:0]  route_device,
	input  wire  [31:0] lookup_addr,
	output logic        done,
	output logic [1:0]  status,
	output logic        matched,
	output logic [3:0]  entry_index,
	output logic [31:0] out_dst,
	output logic [31:0] out_gateway,
	output logic [31:0] out_mask,
	output logic [7:0]  out_flags,
	output logic [31:0] out_metric,
	output logic [3:0]  out_device
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic             busy_q;
	logic             done_q;
	logic [1:0]       status_q;
	logic             matched_q;
	logic [3:0]       index_q;
	frt_pkg::entry_t  res_q;

	frt_pkg::tok_t    tok   [TABLE_DEPTH+1];
	logic [IDX_W-1:0] idx   [TABLE_DEPTH+1];
	logic [TABLE_DEPTH-1:0] wr_en;
	logic [TABLE_DEPTH-1:0] live;

	frt_pkg::entry_t  new_entry;
	logic             acc;
	logic             full;
	logic             empty;
	frt_pkg::tok_t    last_tok;

	always_comb begin
		acc   = start && !busy_q;
		full  = (count_q == CNT_W'(TABLE_DEPTH));
		empty = (count_q == '0);

		new_entry.dst     = route_dst;
		new_entry.gateway = route_gateway;
		new_entry.mask    = route_mask;
		new_entry.flags   = route_flags;
		new_entry.metric  = route_metric;
		new_entry.device  = frt_pkg::DEV_W_MAX'(DEVICE_BITS'(route_device));
	end

	assign tok[0].valid = acc && (mode == frt_pkg::MODE_LOOKUP) && !empty;
	assign tok[0].found = 1'b0;
	assign tok[0].addr  = lookup_addr;
	assign tok[0].entry = '0;
	assign idx[0]       = '0;
	assign last_tok     = tok[TABLE_DEPTH];

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		assign wr_en[i] = acc && (mode == frt_pkg::MODE_ADD) && (count_q == CNT_W'(i));
		assign live[i]  = (count_q > CNT_W'(i));

		frt_cell #(
			.IDX_W       (IDX_W),
			.DEVICE_BITS (DEVICE_BITS),
			.CELL_IDX    (IDX_W'(i))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_en[i]),
			.wr_entry (new_entry),
			.live     (live[i]),
			.tok_in   (tok[i]),
			.idx_in   (idx[i]),
			.tok_out  (tok[i+1]),
			.idx_out  (idx[i+1])
		);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= acc ? !tok[0].valid : last_tok.valid;
			if (last_tok.valid) begin
				busy_q <= 1'b0;
			end else if (tok[0].valid) begin
				busy_q <= 1'b1;
			end
			if (acc) begin
				unique case (mode)
					frt_pkg::MODE_ADD: begin
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					frt_pkg::MODE_CLEAR: count_q <= '0;
					default: ;
				endcase
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (last_tok.valid) begin
			status_q  <= frt_pkg::ST_OK;
			matched_q <= last_tok.found;
			index_q   <= 4'(idx[TABLE_DEPTH]);
			res_q     <= last_tok.entry;
		end else if (acc) begin
			status_q  <= frt_pkg::ST_OK;
			matched_q <= 1'b0;
			index_q   <= '0;
			res_q     <= '0;
			unique case (mode)
				frt_pkg::MODE_ADD: begin
					if (full) begin
						status_q <= frt_pkg::ST_FULL;
					end else begin
						index_q <= 4'(count_q);
						res_q   <= new_entry;
					end
				end
				frt_pkg::MODE_LOOKUP: begin
					if (empty) begin
						status_q <= frt_pkg::ST_NO_ROUTE;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		busy        = busy_q;
		done        = done_q;
		status      = status_q;
		matched     = matched_q;
		entry_index = index_q;
		out_dst     = res_q.dst;
		out_gateway = res_q.gateway;
		out_mask    = res_q.mask;
		out_flags   = res_q.flags;
		out_metric  = res_q.metric;
		out_device  = 4'(res_q.device);
	end

endmodule
`default_nettype wire

>>> dv/first_match_route_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_match_route_table_test: self-checking bench for the route table
// Drives add, lookup and clear commands with random sender gaps, predicts
// each result from a shadow copy of the table and checks every done beat.
// ----------------------------------------------------------------------------
module first_match_route_table_test;
	import frt_pkg::*;

	localparam int DEPTH     = 16;
	localparam int PER_PHASE = 375;

	typedef struct packed {
		logic [31:0] dst;
		logic [31:0] gateway;
		logic [31:0] mask;
		logic [7:0]  flags;
		logic [31:0] metric;
		logic [3:0]  device;
	} route_t;

	typedef struct packed {
		logic [1:0] status;
		logic       matched;
		logic [3:0] entry_index;
		route_t     entry;
	} route_reply_t;

	class route_scoreboard;
		route_t       rows[DEPTH];
		int unsigned  row_count;
		route_reply_t expected_replies[$];
		int unsigned  faults;

		function new();
			row_count = 0;
			faults    = 0;
		endfunction

		// work out the reply to an accepted command and update the shadow table
		function void note_command(logic [1:0] op, route_t rt, logic [31:0] addr);
			route_reply_t r;
			int           hit;
			r   = '0;
			hit = -1;
			case (op)
				MODE_ADD: begin
					if (row_count >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						rows[row_count] = rt;
						r.entry_index   = row_count[3:0];
						r.entry         = rt;
						row_count++;
					end
				end
				MODE_LOOKUP: begin
					if (row_count == 0) begin
						r.status = ST_NO_ROUTE;
					end else begin
						for (int i = 0; i < row_count; i++)
							if (hit < 0 && (addr & rows[i].mask) == (rows[i].dst & rows[i].mask))
								hit = i;
						r.matched = (hit >= 0);
						if (hit < 0)
							hit = row_count - 1;
						r.entry_index = hit[3:0];
						r.entry       = rows[hit];
					end
				end
				MODE_CLEAR: row_count = 0;
				default: ;
			endcase
			expected_replies.push_back(r);
		endfunction

		function void compare_field(string what, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				if (faults < 10)
					$display("route mismatch on %s: expected %h, got %h", what, want, got);
				faults++;
			end
		endfunction

		function void check_result(route_reply_t got);
			route_reply_t want;
			if (expected_replies.size() == 0) begin
				if (faults < 10)
					$display("route reply with nothing outstanding: %p", got);
				faults++;
				return;
			end
			want = expected_replies.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("matched", want.matched, got.matched);
			compare_field("entry_index", want.entry_index, got.entry_index);
			compare_field("dst", want.entry.dst, got.entry.dst);
			compare_field("gateway", want.entry.gateway, got.entry.gateway);
			compare_field("mask", want.entry.mask, got.entry.mask);
			compare_field("flags", want.entry.flags, got.entry.flags);
			compare_field("metric", want.entry.metric, got.entry.metric);
			compare_field("device", want.entry.device, got.entry.device);
		endfunction
	endclass

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        start         = 1'b0;
	logic [1:0]  mode          = MODE_ADD;
	logic [31:0] route_dst     = '0;
	logic [31:0] route_gateway = '0;
	logic [31:0] route_mask    = '0;
	logic [7:0]  route_flags   = '0;
	logic [31:0] route_metric  = '0;
	logic [3:0]  route_device  = '0;
	logic [31:0] lookup_addr   = '0;
	wire         busy;
	wire         done;
	wire  [1:0]  status;
	wire         matched;
	wire  [3:0]  entry_index;
	wire  [31:0] out_dst;
	wire  [31:0] out_gateway;
	wire  [31:0] out_mask;
	wire  [7:0]  out_flags;
	wire  [31:0] out_metric;
	wire  [3:0]  out_device;

	route_scoreboard routes = new();

	first_match_route_table #(
		.TABLE_DEPTH(DEPTH),
		.DEVICE_BITS(4)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.route_dst    (route_dst),
		.route_gateway(route_gateway),
		.route_mask   (route_mask),
		.route_flags  (route_flags),
		.route_metric (route_metric),
		.route_device (route_device),
		.lookup_addr  (lookup_addr),
		.done         (done),
		.status       (status),
		.matched      (matched),
		.entry_index  (entry_index),
		.out_dst      (out_dst),
		.out_gateway  (out_gateway),
		.out_mask     (out_mask),
		.out_flags    (out_flags),
		.out_metric   (out_metric),
		.out_device   (out_device)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			routes.check_result('{status, matched, entry_index,
				'{out_dst, out_gateway, out_mask, out_flags, out_metric, out_device}});
	end

	// holds the beat past an edge until busy is low again, then notes it for prediction
	task automatic drive_command(logic [1:0] op, route_t rt, logic [31:0] addr);
		start         <= 1'b1;
		mode          <= op;
		route_dst     <= rt.dst;
		route_gateway <= rt.gateway;
		route_mask    <= rt.mask;
		route_flags   <= rt.flags;
		route_metric  <= rt.metric;
		route_device  <= rt.device;
		lookup_addr   <= addr;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		routes.note_command(op, rt, addr);
	endtask

	task automatic sender_gap(int unsigned pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < pct);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (routes.expected_replies.size() != 0)
			@(posedge clk);
	endtask

	function automatic route_t random_route();
		route_t      rt;
		int unsigned pick;
		int unsigned plen;
		rt   = {$urandom, $urandom, $urandom, 8'($urandom), $urandom, 4'($urandom)};
		pick = $urandom_range(99);
		plen = $urandom_range(32);
		// mostly prefix masks, some arbitrary ones and the two extremes
		if (pick < 70)
			rt.mask = (plen == 0) ? 32'h0 : (32'hffff_ffff << (32 - plen));
		else if (pick < 90)
			rt.mask = $urandom;
		else
			rt.mask = pick[0] ? 32'hffff_ffff : 32'h0;
		return rt;
	endfunction

	// aim most lookups at a stored route, filling the host bits at random
	function automatic logic [31:0] lookup_target();
		route_t      rt;
		int unsigned k;
		if (routes.row_count == 0 || $urandom_range(99) < 30)
			return $urandom;
		k  = $urandom_range(routes.row_count - 1);
		rt = routes.rows[k];
		return (rt.dst & rt.mask) | ($urandom & ~rt.mask);
	endfunction

	initial begin
		int unsigned idle_pct[4];
		int unsigned pick;
		route_t      rt;
		idle_pct = '{0, 67, 0, 27};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, hit, miss, full table, clear
		drive_command(MODE_LOOKUP, random_route(), 32'h0);
		drive_command(MODE_CLEAR, random_route(), 32'hffff_ffff);
		drive_command(MODE_ADD, '{32'hffff_ffff, 32'h0, 32'hffff_ffff, 8'hff,
			32'hffff_ffff, 4'hf}, $urandom);
		drive_command(MODE_ADD, '{32'h0a00_0000, 32'hffff_ffff, 32'hff00_0000, 8'h00,
			32'h0, 4'h0}, $urandom);
		drive_command(MODE_LOOKUP, random_route(), 32'hffff_ffff);
		drive_command(MODE_LOOKUP, random_route(), 32'h0a12_3456);
		drive_command(MODE_LOOKUP, random_route(), 32'h0b00_0000);
		repeat (13) begin
			rt      = random_route();
			rt.mask = 32'hffff_ffff;
			drive_command(MODE_ADD, rt, $urandom);
		end
		// default route in the last slot: a miss elsewhere walks the full depth
		drive_command(MODE_ADD, '0, $urandom);
		drive_command(MODE_LOOKUP, random_route(), 32'h0b00_0000);
		drive_command(MODE_ADD, random_route(), $urandom);
		drive_command(MODE_CLEAR, random_route(), $urandom);
		drive_command(MODE_LOOKUP, random_route(), $urandom);
		drain();

		foreach (idle_pct[p]) begin
			repeat (PER_PHASE) begin
				sender_gap(idle_pct[p]);
				pick = $urandom_range(99);
				if (pick < 40)
					drive_command(MODE_ADD, random_route(), $urandom);
				else if (pick < 95)
					drive_command(MODE_LOOKUP, random_route(), lookup_target());
				else
					drive_command(MODE_CLEAR, random_route(), $urandom);
			end
			drain();
		end

		repeat (DEPTH + 4) @(posedge clk);
		if (routes.faults == 0 && routes.expected_replies.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
